// File: src/gkm_pkg.sv
`default_nettype none

package gkm_pkg;

    // Button store size and index width
    localparam int NUM_BUTTONS = 16;
    localparam int BTN_W       = $clog2(NUM_BUTTONS);
    localparam int RAW_BITS    = 8;

    // Configuration register widths and reset values
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;
    localparam logic [47:0] FUNC_MAP_RESET  = 48'd1655710138698;
    localparam logic [31:0] RAW_MAP_RESET   = 32'd616356353;
    localparam logic [14:0] THRESHOLD_RESET = 15'd11000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FUNC_MAP  = 2'd0,
        CFG_RAW_MAP   = 2'd1,
        CFG_THRESHOLD = 2'd2,
        CFG_UNUSED    = 2'd3
    } cfg_idx_t;

    // Button function codes
    typedef enum logic [2:0] {
        FN_NONE   = 3'd0,
        FN_GROUP0 = 3'd1,
        FN_GROUP1 = 3'd2,
        FN_GROUP2 = 3'd3,
        FN_ALT    = 3'd4,
        FN_SHIFT  = 3'd5,
        FN_ARROW  = 3'd6,
        FN_RAW    = 3'd7
    } func_t;

    // Event kinds
    localparam logic ACT_AXIS   = 1'b0;
    localparam logic ACT_BUTTON = 1'b1;

    // Stick direction, centre has its own code
    localparam logic [3:0] DIR_CENTRE = 4'd8;

    localparam logic [7:0] CHAR_ESC     = 8'h1B;
    localparam logic [7:0] CHAR_BRACKET = 8'h5B;

    // Input request and result payloads
    typedef struct packed {
        logic               action;
        logic [7:0]         event_index;
        logic signed [15:0] event_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_of_run;
    } out_item_t;

    // One classified job: up to three bytes, last_pos is the final byte slot
    typedef struct packed {
        logic [1:0]      last_pos;
        logic [2:0][7:0] bytes;
    } job_t;

    // Job queue status
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    localparam int GLYPH_ROWS = 12;

    localparam logic [7:0] GLYPH_ROM [0:95] = '{
        "a", "b", "c", "d", "e", "f", "g", "h",
        "i", "j", "k", "l", "m", "n", "o", "p",
        "q", "r", "s", "t", "u", "v", "w", "x",
        "y", "z", "-", ".", " ", "/", 8'h08, ",",
        "0", "1", "2", "3", "4", "5", "6", "7",
        "8", "9", "*", "?", "_", "&", 8'h22, 8'h27,
        "A", "B", "C", "D", "E", "F", "G", "H",
        "I", "J", "K", "L", "M", "N", "O", "P",
        "Q", "R", "S", "T", "U", "V", "W", "X",
        "Y", "Z", ">", "<", "|", 8'h00, 8'h0D, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Look up one character by table row and direction
    function automatic logic [7:0] glyph_lookup(input logic [3:0] row, input logic [2:0] dir);
        logic [7:0] c;
        c = 8'h00;
        if (int'(row) < GLYPH_ROWS)
        begin
            c = GLYPH_ROM[int'({row, dir})];
        end
        return c;
    endfunction

    // Final letter of the arrow escape for directions 0, 2, 4, 6
    function automatic logic [7:0] arrow_tail(input logic [1:0] sel);
        logic [7:0] c;
        case (sel)
            2'd0:    c = "A";
            2'd1:    c = "C";
            2'd2:    c = "B";
            default: c = "D";
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/gamepad_to_keystroke_mapper_unit.sv
`default_nettype none

// Channel    Ports                          Moves on
// --------   ----------------------------   ------------------------
// event      push, full, joy_event          push && !full
// keystroke  empty, pop, keystroke          pop && !empty
// config     cfg_we, cfg_index, cfg_data    cfg_we
//
// An event request is accepted every cycle while the four-entry job queue has
// room; the front classifies it in the accept cycle. The back emits one byte
// per cycle from the queue head while the results are popped, so a character
// or raw press gives one byte and an arrow press three. The first byte passes
// through the job queue and the output register on its way to the result ports.
// Reset restores all configuration and control state at once; no clear pass.
// A stalled result holds in the output register while the queue keeps filling.

module gamepad_to_keystroke_mapper_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire gkm_pkg::in_item_t               joy_event,
    output logic                                 empty,
    input  wire logic                            pop,
    output gkm_pkg::out_item_t                   keystroke,
    input  wire logic                            cfg_we,
    input  wire logic [gkm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gkm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    gkm_pkg::job_t       new_job, head_job;
    gkm_pkg::fifo_stat_t job_stat;
    logic                job_push, job_pop;
    logic                accept;

    assign full   = job_stat.full;
    assign accept = push && !full;

    gkm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (joy_event),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job       (new_job),
        .job_push  (job_push)
    );

    gkm_job_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (new_job),
        .pop      (job_pop),
        .head_job (head_job),
        .stat     (job_stat)
    );

    gkm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (head_job),
        .job_stat (job_stat),
        .job_pop  (job_pop),
        .result   (keystroke),
        .empty    (empty),
        .pop      (pop)
    );

    // The back never pops an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> !job_stat.empty)
        else $error("job queue popped while empty");

    // The front never pushes into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !job_stat.full)
        else $error("job queue pushed while full");

    // A run continues without a gap once a non-final byte is taken
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !keystroke.last_of_run) |=> !empty)
        else $error("gap inside a keystroke run");

    // A non-final byte always leaves its job in the queue
    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !keystroke.last_of_run) |-> !job_stat.empty)
        else $error("job left queue before its last byte");

endmodule

`default_nettype wire

// File: src/gkm_front.sv
`default_nettype none

module gkm_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire gkm_pkg::in_item_t               item,
    input  wire logic                            cfg_we,
    input  wire logic [gkm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gkm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output gkm_pkg::job_t                        job,
    output logic                                 job_push
);

    logic [47:0]                       func_map_reg, func_map_next;
    logic [31:0]                       raw_map_reg, raw_map_next;
    logic [14:0]                       thr_reg, thr_next;
    logic signed [15:0]                stick_x_reg, stick_x_next;
    logic signed [15:0]                stick_y_reg, stick_y_next;
    logic [gkm_pkg::NUM_BUTTONS-1:0]   held_reg, held_next;
    logic                              shift_reg, shift_next;
    logic                              alt_reg, alt_next;

    logic                              idx_ok;
    logic [gkm_pkg::BTN_W-1:0]         bidx;
    gkm_pkg::func_t                    fn;
    logic                              pressed;
    logic signed [16:0]                t_pos, t_neg, sx, sy;
    logic [3:0]                        dir;
    logic [3:0]                        row;
    logic [1:0]                        grp;
    logic [7:0]                        glyph;
    logic [7:0]                        raw_byte;
    logic                              emit;

    // Decode the button and its function
    assign idx_ok  = item.event_index < 8'(gkm_pkg::NUM_BUTTONS);
    assign bidx    = item.event_index[gkm_pkg::BTN_W-1:0];
    assign fn      = gkm_pkg::func_t'(func_map_reg[3 * int'(bidx) +: 3]);
    assign pressed = item.event_value != 16'sd0;

    // Quantize the stick against the threshold
    assign t_pos = signed'({2'b00, thr_reg});
    assign t_neg = -t_pos;
    assign sx    = 17'(stick_x_reg);
    assign sy    = 17'(stick_y_reg);

    always_comb
    begin
        if (sy > t_pos)
        begin
            if (sx > t_pos)      dir = 4'd1;
            else if (sx > t_neg) dir = 4'd0;
            else                 dir = 4'd7;
        end
        else if (sy < t_neg)
        begin
            if (sx > t_pos)      dir = 4'd3;
            else if (sx > t_neg) dir = 4'd4;
            else                 dir = 4'd5;
        end
        else if (sx > t_pos)     dir = 4'd2;
        else if (sx < t_neg)     dir = 4'd6;
        else                     dir = gkm_pkg::DIR_CENTRE;
    end

    // Pick the character from the table
    assign grp   = 2'(fn) - 2'd1;
    assign row   = (shift_reg ? 4'd6 : 4'd0) + (alt_reg ? 4'd3 : 4'd0) + {2'b00, grp};
    assign glyph = gkm_pkg::glyph_lookup(row, dir[2:0]);

    // Pack the raw byte from the held levels before this event
    always_comb
    begin
        logic [3:0] nib;
        raw_byte = 8'h00;
        for (int i = 0; i < gkm_pkg::RAW_BITS; i++)
        begin
            nib = raw_map_reg[4 * i +: 4];
            raw_byte[i] = (int'(nib) < gkm_pkg::NUM_BUTTONS)
                          && held_reg[nib[gkm_pkg::BTN_W-1:0]];
        end
    end

    // Classify the request into a job
    always_comb
    begin
        job.last_pos = 2'd0;
        job.bytes    = '0;
        emit         = 1'b0;
        case (fn)
            gkm_pkg::FN_GROUP0, gkm_pkg::FN_GROUP1, gkm_pkg::FN_GROUP2:
            begin
                job.bytes[0] = glyph;
                emit = (dir != gkm_pkg::DIR_CENTRE) && (glyph != 8'h00);
            end
            gkm_pkg::FN_ARROW:
            begin
                job.last_pos = 2'd2;
                job.bytes[0] = gkm_pkg::CHAR_ESC;
                job.bytes[1] = gkm_pkg::CHAR_BRACKET;
                job.bytes[2] = gkm_pkg::arrow_tail(dir[2:1]);
                emit = (dir != gkm_pkg::DIR_CENTRE) && !dir[0];
            end
            gkm_pkg::FN_RAW:
            begin
                job.bytes[0] = raw_byte;
                emit = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign job_push = accept && (item.action == gkm_pkg::ACT_BUTTON) && idx_ok
                      && pressed && emit;

    // Compute state and configuration updates
    always_comb
    begin
        func_map_next = func_map_reg;
        raw_map_next  = raw_map_reg;
        thr_next      = thr_reg;
        stick_x_next  = stick_x_reg;
        stick_y_next  = stick_y_reg;
        held_next     = held_reg;
        shift_next    = shift_reg;
        alt_next      = alt_reg;

        if (cfg_we)
        begin
            case (gkm_pkg::cfg_idx_t'(cfg_index))
                gkm_pkg::CFG_FUNC_MAP:  func_map_next = cfg_data[47:0];
                gkm_pkg::CFG_RAW_MAP:   raw_map_next  = cfg_data[31:0];
                gkm_pkg::CFG_THRESHOLD: thr_next      = cfg_data[14:0];
                default:                func_map_next = func_map_reg;
            endcase
        end

        if (accept)
        begin
            if (item.action == gkm_pkg::ACT_AXIS)
            begin
                if (item.event_index == 8'd0)      stick_x_next = item.event_value;
                else if (item.event_index == 8'd1) stick_y_next = item.event_value;
            end
            else if (idx_ok)
            begin
                held_next[bidx] = pressed;
                if (fn == gkm_pkg::FN_ALT)   alt_next   = pressed;
                if (fn == gkm_pkg::FN_SHIFT) shift_next = pressed;
            end
        end
    end

    // Hold state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_map_reg <= gkm_pkg::FUNC_MAP_RESET;
            raw_map_reg  <= gkm_pkg::RAW_MAP_RESET;
            thr_reg      <= gkm_pkg::THRESHOLD_RESET;
            stick_x_reg  <= '0;
            stick_y_reg  <= '0;
            held_reg     <= '0;
            shift_reg    <= 1'b0;
            alt_reg      <= 1'b0;
        end
        else
        begin
            func_map_reg <= func_map_next;
            raw_map_reg  <= raw_map_next;
            thr_reg      <= thr_next;
            stick_x_reg  <= stick_x_next;
            stick_y_reg  <= stick_y_next;
            held_reg     <= held_next;
            shift_reg    <= shift_next;
            alt_reg      <= alt_next;
        end
    end

endmodule

`default_nettype wire

// File: src/gkm_job_fifo.sv
`default_nettype none

module gkm_job_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire gkm_pkg::job_t  push_job,
    input  wire logic           pop,
    output gkm_pkg::job_t       head_job,
    output gkm_pkg::fifo_stat_t stat
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    gkm_pkg::job_t    slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.full  = count_reg == (PTR_W + 1)'(DEPTH);
    assign stat.empty = count_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_job   = slots_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the job payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// File: src/gkm_back.sv
`default_nettype none

module gkm_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gkm_pkg::job_t       job,
    input  wire gkm_pkg::fifo_stat_t job_stat,
    output logic                     job_pop,
    output gkm_pkg::out_item_t       result,
    output logic                     empty,
    input  wire logic                pop
);

    logic [1:0]         pos_reg, pos_next;
    logic               valid_reg, valid_next;
    gkm_pkg::out_item_t result_reg;
    logic               load;
    logic               at_last;

    // Load the next byte when the output slot frees up
    assign load    = !job_stat.empty && (!valid_reg || pop);
    assign at_last = pos_reg == job.last_pos;
    assign job_pop = load && at_last;

    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            pos_next   = at_last ? 2'd0 : pos_reg + 2'd1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    // Capture the result byte
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.char_out    <= job.bytes[pos_reg];
            result_reg.last_of_run <= at_last;
        end
    end

    assign result = result_reg;
    assign empty  = !valid_reg;

endmodule

`default_nettype wire

// File: tb/sv/gkm_keystroke_checker.sv
`default_nettype none

// Watch the event, keystroke and config channels, predict the keystrokes of
// each accepted event request and compare them in order.
module gkm_keystroke_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    input  wire logic                            full,
    input  wire gkm_pkg::in_item_t               joy_event,
    input  wire logic                            empty,
    input  wire logic                            pop,
    input  wire gkm_pkg::out_item_t              keystroke,
    input  wire logic                            cfg_we,
    input  wire logic [gkm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gkm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                   mismatches,
    output int                                   outstanding
);

    import gkm_pkg::*;

    // Shadow configuration
    logic [47:0] func_map;
    logic [31:0] raw_map;
    logic [14:0] threshold;

    // Shadow state
    logic signed [15:0]     stick_x;
    logic signed [15:0]     stick_y;
    logic [NUM_BUTTONS-1:0] held;
    logic                   shift_on;
    logic                   alt_on;

    out_item_t expected_keys[$];

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic reset_shadow();
        func_map  = 48'd1655710138698;
        raw_map   = 32'd616356353;
        threshold = 15'd11000;
        stick_x   = '0;
        stick_y   = '0;
        held      = '0;
        shift_on  = 1'b0;
        alt_on    = 1'b0;
        mismatches = 0;
        expected_keys.delete();
    endtask

    // Quantize the stick: 0..7 clockwise from up, or centre
    function automatic logic [3:0] stick_direction();
        int t;
        int x;
        int y;
        logic [3:0] d;
        t = int'(threshold);
        x = int'(stick_x);
        y = int'(stick_y);
        if (y > t)
        begin
            if (x > t)       d = 4'd1;
            else if (x > -t) d = 4'd0;
            else             d = 4'd7;
        end
        else if (y < -t)
        begin
            if (x > t)       d = 4'd3;
            else if (x > -t) d = 4'd4;
            else             d = 4'd5;
        end
        else if (x > t)      d = 4'd2;
        else if (x < -t)     d = 4'd6;
        else                 d = DIR_CENTRE;
        return d;
    endfunction

    // Character table: rows 0..2 plain, +3 alternate shift, +6 shift
    function automatic logic [7:0] glyph(input int row, input logic [2:0] dir);
        logic [63:0] line;
        case (row)
            0:       line = "abcdefgh";
            1:       line = "ijklmnop";
            2:       line = "qrstuvwx";
            3:       line = {"yz-. /", 8'h08, ","};
            4:       line = "01234567";
            5:       line = {"89*?_&", 8'h22, 8'h27};
            6:       line = "ABCDEFGH";
            7:       line = "IJKLMNOP";
            8:       line = "QRSTUVWX";
            9:       line = {"YZ><|", 8'h00, 8'h0D, 8'h00};
            default: line = '0;
        endcase
        return line[63 - 8 * int'(dir) -: 8];
    endfunction

    // Update the shadow state and queue the keystrokes of one event request
    task automatic predict_keystrokes(input in_item_t ev);
        logic [7:0] run[$];
        logic       pressed;
        logic [3:0] dir;
        logic [7:0] c;
        logic [7:0] raw_byte;
        func_t      fn;
        int         bi;
        int         row;
        out_item_t  k;
        pressed = (ev.event_value != 16'sd0);
        bi = int'(ev.event_index);
        if (ev.action == ACT_AXIS)
        begin
            if (bi == 0)      stick_x = ev.event_value;
            else if (bi == 1) stick_y = ev.event_value;
        end
        else if (bi < NUM_BUTTONS)
        begin
            fn = func_t'(func_map[3 * bi +: 3]);
            case (fn)
                FN_GROUP0, FN_GROUP1, FN_GROUP2:
                begin
                    dir = stick_direction();
                    if (pressed && dir != DIR_CENTRE)
                    begin
                        row = (shift_on ? 6 : 0) + (alt_on ? 3 : 0)
                            + (int'(fn) - int'(FN_GROUP0));
                        c = glyph(row, dir[2:0]);
                        if (c != 8'h00)
                            run.push_back(c);
                    end
                end
                FN_ALT:   alt_on = pressed;
                FN_SHIFT: shift_on = pressed;
                FN_ARROW:
                begin
                    dir = stick_direction();
                    // Only the four straight directions have an arrow
                    if (pressed && dir != DIR_CENTRE && !dir[0])
                    begin
                        run.push_back(CHAR_ESC);
                        run.push_back(CHAR_BRACKET);
                        case (dir)
                            4'd0:    run.push_back("A");
                            4'd2:    run.push_back("C");
                            4'd4:    run.push_back("B");
                            default: run.push_back("D");
                        endcase
                    end
                end
                FN_RAW:
                begin
                    // Sample held levels before this button's own level lands
                    if (pressed)
                    begin
                        for (int i = 0; i < RAW_BITS; i++)
                            raw_byte[i] = held[raw_map[4 * i +: 4]];
                        run.push_back(raw_byte);
                    end
                end
                default: ;
            endcase
            held[bi] = pressed;
        end
        foreach (run[i])
        begin
            k.char_out    = run[i];
            k.last_of_run = (i == run.size() - 1);
            expected_keys.push_back(k);
        end
    endtask

    task automatic check_keystroke(input out_item_t got);
        out_item_t want;
        if (expected_keys.size() == 0)
        begin
            report_mismatch($sformatf("unexpected keystroke %02h last %0b",
                                      got.char_out, got.last_of_run));
            return;
        end
        want = expected_keys.pop_front();
        if (got.char_out !== want.char_out)
            report_mismatch($sformatf("char_out got %02h want %02h",
                                      got.char_out, want.char_out));
        if (got.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run got %0b want %0b on char %02h",
                                      got.last_of_run, want.last_of_run, want.char_out));
    endtask

    // Sample all channels at the rising edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reset_shadow();
        end
        else
        begin
            if (pop && !empty)
                check_keystroke(keystroke);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FUNC_MAP:  func_map = cfg_data;
                    CFG_RAW_MAP:   raw_map = cfg_data[31:0];
                    CFG_THRESHOLD: threshold = cfg_data[14:0];
                    default: ;
                endcase
            end
            if (push && !full)
                predict_keystrokes(joy_event);
        end
        outstanding = expected_keys.size();
    end

endmodule

`default_nettype wire

// File: tb/sv/gamepad_to_keystroke_mapper_unit_test.sv
`default_nettype none

module gamepad_to_keystroke_mapper_unit_test;

    import gkm_pkg::*;

    localparam int SETTLE_CYCLES   = 24;
    localparam int PRESSURE_CYCLES = 150;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    in_item_t              joy_event;
    logic                  empty;
    logic                  pop;
    out_item_t             keystroke;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int          mismatches;
    int          outstanding;
    logic [14:0] cur_threshold = 15'd11000;
    logic        pressure_req = 1'b0;
    logic        pressure_served = 1'b0;

    gamepad_to_keystroke_mapper_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .joy_event (joy_event),
        .empty     (empty),
        .pop       (pop),
        .keystroke (keystroke),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gkm_keystroke_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .joy_event   (joy_event),
        .empty       (empty),
        .pop         (pop),
        .keystroke   (keystroke),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one event request from a falling edge until it is taken
    task automatic send_event(input logic act, input logic [7:0] idx,
                              input logic [15:0] val);
        joy_event = {act, idx, val};
        push = 1'b1;
        do @(posedge clk); while (full);
        @(negedge clk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [47:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Drop push and let every queued and in-flight request drain
    task automatic wait_idle();
        push = 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Drain, then load all three registers; narrow ones carry noise above
    task automatic start_phase(input logic [47:0] func_map, input logic [31:0] raw_map,
                               input logic [14:0] thr);
        wait_idle();
        write_register(CFG_FUNC_MAP, func_map);
        write_register(CFG_RAW_MAP, {16'($urandom()), raw_map});
        write_register(CFG_THRESHOLD, {33'($urandom()), thr});
        cur_threshold = thr;
    endtask

    // Aim axis values at the threshold edges and the extremes
    function automatic logic [15:0] axis_value();
        int t;
        t = int'(cur_threshold);
        case ($urandom_range(0, 7))
            0:       return 16'(t);
            1:       return 16'(-t);
            2:       return 16'(t + 1);
            3:       return 16'(-t - 1);
            4:       return 16'h7FFF;
            5:       return 16'h8000;
            6:       return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_random_event();
        int          pick;
        logic [15:0] level;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            send_event(ACT_AXIS, 8'($urandom_range(0, 1)), axis_value());
        end
        else if (pick < 36)
        begin
            send_event(1'($urandom()), 8'($urandom()), 16'($urandom()));
        end
        else
        begin
            level = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
            send_event(ACT_BUTTON, 8'($urandom_range(0, NUM_BUTTONS - 1)), level);
        end
    endtask

    // Send requests in bursts of random length with random gaps
    task automatic run_random(input int count);
        int burst;
        int gap;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                push = 1'b0;
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                repeat (gap) @(negedge clk);
                burst = $urandom_range(1, 16);
            end
            send_random_event();
            burst--;
        end
        push = 1'b0;
    endtask

    // Result side: stall on its own pattern, with one long hold-off on request
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        pop  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pressure_req && !pressure_served)
            begin
                pop = 1'b0;
                repeat (PRESSURE_CYCLES) @(negedge clk);
                pressure_served = 1'b1;
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(5, 40);
            end
            left--;
            case (mode)
                0:       pop = 1'b1;
                1:       pop = ($urandom_range(0, 3) != 0);
                2:       pop = 1'($urandom());
                default: pop = ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Stimulus and verdict
    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        joy_event = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_FUNC_MAP;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Hit the unused register index; it must change nothing
        write_register(CFG_UNUSED, {16'($urandom()), 32'($urandom())});

        // Directed pass on the reset configuration
        send_event(ACT_BUTTON, 8'd5, 16'h0001);    // raw byte with nothing held
        send_event(ACT_BUTTON, 8'd5, 16'h0000);
        send_event(ACT_BUTTON, 8'd1, 16'h0001);    // stick centred
        send_event(ACT_AXIS, 8'd1, 16'h7FFF);
        send_event(ACT_AXIS, 8'd0, 16'h8000);      // up-left
        send_event(ACT_BUTTON, 8'd1, 16'hFFFF);
        send_event(ACT_BUTTON, 8'd2, 16'h8000);    // shift on
        send_event(ACT_BUTTON, 8'd1, 16'h0001);
        send_event(ACT_BUTTON, 8'd4, 16'h0005);    // alternate shift on
        send_event(ACT_BUTTON, 8'd1, 16'h0001);    // empty table entry
        send_event(ACT_BUTTON, 8'd0, 16'h0001);    // blank rows
        send_event(ACT_BUTTON, 8'd13, 16'h0001);
        send_event(ACT_BUTTON, 8'd4, 16'h0000);
        send_event(ACT_BUTTON, 8'd2, 16'h0000);
        send_event(ACT_AXIS, 8'd0, 16'd11000);     // on the threshold, not pushed
        send_event(ACT_BUTTON, 8'd10, 16'h0001);   // arrow up
        send_event(ACT_AXIS, 8'd0, 16'd11001);
        send_event(ACT_BUTTON, 8'd10, 16'h0001);   // diagonal, no arrow
        send_event(ACT_BUTTON, 8'd13, 16'h0001);
        send_event(ACT_AXIS, 8'd7, 16'd1234);      // unknown axis
        send_event(ACT_BUTTON, 8'd200, 16'h0001);  // unknown button
        send_event(ACT_BUTTON, 8'd3, 16'h0001);    // no function
        send_event(ACT_BUTTON, 8'd5, 16'h0002);    // raw byte from held buttons
        send_event(ACT_BUTTON, 8'd0, 16'h0001);
        push = 1'b0;

        run_random(60);

        start_phase({16'($urandom()), 32'($urandom())}, 32'($urandom()), 15'd0);
        run_random(80);

        start_phase('1, '1, 15'h7FFF);
        run_random(40);

        start_phase('0, '0, 15'd1);
        run_random(20);

        start_phase({16'($urandom()), 32'($urandom())}, 32'($urandom()), 15'($urandom()));
        run_random(100);

        // Every button an arrow, stick up; hold results off and keep pushing
        start_phase(48'hDB6_DB6_DB6_DB6, 32'($urandom()), 15'd100);
        send_event(ACT_AXIS, 8'd1, 16'd5000);
        send_event(ACT_AXIS, 8'd0, 16'd0);
        pressure_req = 1'b1;
        for (int n = 0; n < 30; n++)
            send_event(ACT_BUTTON, 8'($urandom_range(0, NUM_BUTTONS - 1)), 16'h0001);
        push = 1'b0;

        start_phase({16'($urandom()), 32'($urandom())}, 32'($urandom()),
                    15'($urandom_range(8000, 14000)));
        run_random(130);

        wait_idle();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
